/* sv/tsm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and constants of the three-tap sparse mix layer
// Holds the mode codes, the command and status bundles between controller
// and datapath, and the saturation helper.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam logic [2:0] MODE_LOAD  = 3'd0;
    localparam logic [2:0] MODE_FWD   = 3'd1;
    localparam logic [2:0] MODE_BWD   = 3'd2;
    localparam logic [2:0] MODE_PGRAD = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic [1:0] LAST_TAP = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       vec_wr;
        logic       mem_rd;
        logic       mul_en;
        logic       acc_en;
        logic       out_load;
        logic [1:0] tap;
    } tsm_cmd_t;

    typedef struct packed {
        logic clr_busy;
        logic out_free;
    } tsm_stat_t;

    // Clamps a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -50'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/tsm_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_ram: generic single-port RAM
// One write and one read per cycle at one shared address; the read data is registered.
// ----------------------------------------------------------------------------
module tsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire                       re,
    input  wire [$clog2(DEPTH)-1:0]   addr,
    input  wire [WIDTH-1:0]           wdata,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire

/* sv/tsm_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_datapath: item registers, stores, multiplier and output register
// Runs one tap per read, multiply and accumulate step as commanded, and
// clears the gradient store after reset.
// ----------------------------------------------------------------------------
module tsm_datapath
    import tsm_pkg::*;
#(
    parameter int VEC_DEPTH = 1024
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  tsm_cmd_t            cmd,
    output tsm_stat_t           st,
    input  wire [2:0]           mode,
    input  wire [9:0]           addr,
    input  wire signed [31:0]   value,
    input  wire [9:0]           idx0,
    input  wire [9:0]           idx1,
    input  wire [9:0]           idx2,
    input  wire signed [31:0]   weight0,
    input  wire signed [31:0]   weight1,
    input  wire signed [31:0]   weight2,
    input  wire                 row_last,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic signed [31:0]  out0,
    output logic signed [31:0]  out1,
    output logic signed [31:0]  out2,
    output logic                last
);

    localparam int AW = $clog2(VEC_DEPTH);
    localparam int IW = (AW > 10) ? AW : 10;

    logic [2:0]         mode_reg;
    logic [9:0]         addr_reg;
    logic signed [31:0] value_reg;
    logic [9:0]         idx_reg [3];
    logic signed [31:0] w_reg [3];
    logic               last_reg;

    logic signed [47:0] prod_reg;
    logic signed [49:0] acc_reg;
    logic signed [31:0] gq_reg;
    logic signed [31:0] res_reg [3];

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] out0_reg;
    logic signed [31:0] out1_reg;
    logic signed [31:0] out2_reg;
    logic               out_last_reg;

    logic               clr_busy_reg;
    logic [AW-1:0]      clr_cnt_reg;

    logic [9:0]         sel_idx;
    logic [IW-1:0]      ext_idx;
    logic               in_range;
    logic [AW-1:0]      mem_addr;
    logic signed [31:0] w_sel;
    logic [31:0]        vec_rdata;
    logic [31:0]        grad_rdata;
    logic signed [31:0] vec_q;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] full_prod;
    logic signed [49:0] grad_sum;
    logic signed [31:0] grad_wdata;
    logic               grad_we;
    logic               grad_re;
    logic [AW-1:0]      grad_addr;

    // Load and read-clear address the store by addr, the tap modes by index.
    always_comb
    begin
        if (mode_reg == MODE_LOAD || mode_reg == MODE_READ)
        begin
            sel_idx = addr_reg;
        end
        else
        begin
            sel_idx = idx_reg[cmd.tap];
        end
    end

    assign ext_idx  = IW'(sel_idx);
    assign in_range = (32'(ext_idx) < 32'(VEC_DEPTH));
    assign mem_addr = ext_idx[AW-1:0];
    assign w_sel    = w_reg[cmd.tap];

    tsm_ram #(.WIDTH(32), .DEPTH(VEC_DEPTH)) u_vec_ram (
        .clk   (clk),
        .we    (cmd.vec_wr & in_range),
        .re    (cmd.mem_rd),
        .addr  (mem_addr),
        .wdata (value_reg),
        .rdata (vec_rdata)
    );

    assign grad_sum = {{18{gq_reg[31]}}, gq_reg} + {{2{prod_reg[47]}}, prod_reg};

    always_comb
    begin
        grad_wdata = '0;
        if (!clr_busy_reg && mode_reg == MODE_BWD)
        begin
            grad_wdata = sat32(grad_sum);
        end
    end

    assign grad_we = clr_busy_reg
                   | (cmd.acc_en & in_range
                      & (mode_reg == MODE_BWD || mode_reg == MODE_READ));
    assign grad_re   = cmd.mem_rd & ~clr_busy_reg;
    assign grad_addr = clr_busy_reg ? clr_cnt_reg : mem_addr;

    tsm_ram #(.WIDTH(32), .DEPTH(VEC_DEPTH)) u_grad_ram (
        .clk   (clk),
        .we    (grad_we),
        .re    (grad_re),
        .addr  (grad_addr),
        .wdata (grad_wdata),
        .rdata (grad_rdata)
    );

    // The tap index stays put from the read to the multiply step.
    assign vec_q = in_range ? $signed(vec_rdata) : 32'sd0;

    always_comb
    begin
        case (mode_reg)
            MODE_FWD:
            begin
                op_a = vec_q;
                op_b = w_sel;
            end
            MODE_BWD:
            begin
                op_a = w_sel;
                op_b = value_reg;
            end
            MODE_PGRAD:
            begin
                op_a = vec_q;
                op_b = value_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign full_prod = op_a * op_b;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            addr_reg  <= addr;
            value_reg <= value;
            idx_reg[0] <= idx0;
            idx_reg[1] <= idx1;
            idx_reg[2] <= idx2;
            w_reg[0]  <= weight0;
            w_reg[1]  <= weight1;
            w_reg[2]  <= weight2;
            last_reg  <= row_last;
            acc_reg   <= '0;
            res_reg[0] <= '0;
            res_reg[1] <= '0;
            res_reg[2] <= '0;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= full_prod[63:16];
            gq_reg   <= $signed(grad_rdata);
        end
        if (cmd.acc_en)
        begin
            case (mode_reg)
                MODE_FWD:
                begin
                    acc_reg <= acc_reg + {{2{prod_reg[47]}}, prod_reg};
                end
                MODE_PGRAD:
                begin
                    res_reg[cmd.tap] <= sat32({{2{prod_reg[47]}}, prod_reg});
                end
                MODE_READ:
                begin
                    res_reg[0] <= in_range ? gq_reg : 32'sd0;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out0_reg     <= (mode_reg == MODE_FWD) ? sat32(acc_reg) : res_reg[0];
            out1_reg     <= res_reg[1];
            out2_reg     <= res_reg[2];
            out_last_reg <= last_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(VEC_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign st.clr_busy = clr_busy_reg;
    assign st.out_free = ~out_valid_reg | out_ready;

    assign out_valid = out_valid_reg;
    assign out0      = out0_reg;
    assign out1      = out1_reg;
    assign out2      = out2_reg;
    assign last      = out_last_reg;

endmodule
`default_nettype wire

/* sv/tsm_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_ctrl: sequencing state machine
// Accepts an item, does a load or steps the taps through read, multiply
// and accumulate, and hands any result to the output register.
// ----------------------------------------------------------------------------
module tsm_ctrl
    import tsm_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire [2:0]   mode,
    input  tsm_stat_t   st,
    output tsm_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] tap_reg;
    logic [1:0] tap_next;
    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) & ~st.clr_busy;
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        cmd.tap    = tap_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    mode_next   = mode;
                    tap_next    = '0;
                    case (mode)
                        MODE_LOAD:
                        begin
                            state_next = S_LOAD;
                        end
                        MODE_FWD, MODE_BWD, MODE_PGRAD, MODE_READ:
                        begin
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.vec_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (mode_reg == MODE_READ || tap_reg == LAST_TAP)
                begin
                    state_next = (mode_reg == MODE_BWD) ? S_IDLE : S_FIN;
                end
                else
                begin
                    tap_next   = tap_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
            mode_reg  <= MODE_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            mode_reg  <= mode_next;
        end
    end

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tap_reg != 2'd3)
        else $error("tap counter ran past the last tap");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        st.clr_busy |-> !in_ready)
        else $error("item accepted during gradient clear");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("output register overwritten");

    a_bwd_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && mode_reg == MODE_BWD && tap_reg == LAST_TAP)
        |=> state_reg == S_IDLE)
        else $error("backward row did not finish quietly");

endmodule
`default_nettype wire

/* sv/three_tap_sparse_mix_layer.sv */
`default_nettype none
// Sequence: a load writes one vector entry, a read-and-clear returns and zeroes one
// gradient entry; forward and parameter-gradient rows give a result, backward none.
// Throughput: one item at a time; the taps of a row pass in turn through the single
// port of each store, each tap taking a read, a multiply and an accumulate step.
// Reset: after rst_n rises the gradient store is cleared one entry per cycle, which
// holds in_ready low until the last entry is cleared.
// ----------------------------------------------------------------------------
// three_tap_sparse_mix_layer: sparse gather multiply-accumulate layer
// Forward, backward, parameter-gradient and gradient read-out over a vector
// store and a gradient store, signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
module three_tap_sparse_mix_layer
    import tsm_pkg::*;
#(
    parameter int VEC_DEPTH = 1024
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire [2:0]           mode,
    input  wire [9:0]           addr,
    input  wire signed [31:0]   value,
    input  wire [9:0]           idx0,
    input  wire [9:0]           idx1,
    input  wire [9:0]           idx2,
    input  wire signed [31:0]   weight0,
    input  wire signed [31:0]   weight1,
    input  wire signed [31:0]   weight2,
    input  wire                 row_last,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic signed [31:0]  out0,
    output logic signed [31:0]  out1,
    output logic signed [31:0]  out2,
    output logic                last
);

    // The controller only sequences; all item data stays in the datapath.
    tsm_cmd_t  cmd;
    tsm_stat_t st;

    tsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .st       (st),
        .cmd      (cmd)
    );

    // The output register lets the next beat enter while a result waits.
    tsm_datapath #(.VEC_DEPTH(VEC_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .mode      (mode),
        .addr      (addr),
        .value     (value),
        .idx0      (idx0),
        .idx1      (idx1),
        .idx2      (idx2),
        .weight0   (weight0),
        .weight1   (weight1),
        .weight2   (weight2),
        .row_last  (row_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out0      (out0),
        .out1      (out1),
        .out2      (out2),
        .last      (last)
    );

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the three-tap sparse mix layer
// Sends load, forward, backward, parameter-gradient, read-and-clear and unused
// beats. A model of both stores in the bench predicts every result, and the
// results are compared field by field in order. Sender and receiver gaps
// change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top
    import tsm_pkg::*;
();

    localparam int DEPTH      = 1024;
    localparam int RAND_ITEMS = 1130;
    localparam int DRAIN_CYC  = 40;

    // Unused mode codes. The package names only the five modes that do work.
    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    typedef struct {
        logic signed [31:0] out0;
        logic signed [31:0] out1;
        logic signed [31:0] out2;
        logic               last;
    } mix_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         mode = '0;
    logic [9:0]         addr = '0;
    logic signed [31:0] value = '0;
    logic [9:0]         idx0 = '0;
    logic [9:0]         idx1 = '0;
    logic [9:0]         idx2 = '0;
    logic signed [31:0] weight0 = '0;
    logic signed [31:0] weight1 = '0;
    logic signed [31:0] weight2 = '0;
    logic               row_last = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] out0;
    logic signed [31:0] out1;
    logic signed [31:0] out2;
    logic               last;

    // Bench copy of both stores. Only entries that have been loaded are ever
    // gathered by forward or parameter-gradient beats.
    logic signed [31:0] act_mirror [DEPTH];
    logic signed [31:0] grad_mirror [DEPTH];
    bit                 act_loaded [DEPTH];
    int                 loaded_list [$];
    mix_result_t        pending_results [$];

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    three_tap_sparse_mix_layer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .addr      (addr),
        .value     (value),
        .idx0      (idx0),
        .idx1      (idx1),
        .idx2      (idx2),
        .weight0   (weight0),
        .weight1   (weight1),
        .weight2   (weight2),
        .row_last  (row_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out0      (out0),
        .out1      (out1),
        .out2      (out2),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver decides once per cycle, at the falling edge, whether it
    // stalls the next rising edge.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Q16.16 product, kept exact and then shifted with floor rounding. The
    // arithmetic shift of a signed 64-bit value rounds toward minus infinity.
    function automatic longint qmul(input logic signed [31:0] a,
                                    input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Applies one accepted beat to the store mirrors and queues the result
    // that it is to produce, if any.
    task automatic predict_layer_beat();
        logic [9:0]         taps [3];
        logic signed [31:0] wts [3];
        longint             sum;
        mix_result_t        r;
        taps = '{idx0, idx1, idx2};
        wts  = '{weight0, weight1, weight2};
        r.out0 = '0;
        r.out1 = '0;
        r.out2 = '0;
        r.last = row_last;
        case (mode)
            MODE_LOAD:
            begin
                act_mirror[addr] = value;
                if (!act_loaded[addr])
                begin
                    act_loaded[addr] = 1'b1;
                    loaded_list.push_back(addr);
                end
            end
            MODE_FWD:
            begin
                sum = 0;
                for (int k = 0; k < 3; k++)
                begin
                    sum += qmul(act_mirror[taps[k]], wts[k]);
                end
                r.out0 = clamp32(sum);
                pending_results.push_back(r);
            end
            MODE_BWD:
            begin
                // Taps update in order, so a repeated index sees the earlier sum.
                for (int k = 0; k < 3; k++)
                begin
                    grad_mirror[taps[k]] =
                        clamp32(longint'(grad_mirror[taps[k]]) + qmul(wts[k], value));
                end
            end
            MODE_PGRAD:
            begin
                r.out0 = clamp32(qmul(act_mirror[taps[0]], value));
                r.out1 = clamp32(qmul(act_mirror[taps[1]], value));
                r.out2 = clamp32(qmul(act_mirror[taps[2]], value));
                pending_results.push_back(r);
            end
            MODE_READ:
            begin
                r.out0 = grad_mirror[addr];
                grad_mirror[addr] = '0;
                pending_results.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    // Drives one beat at a falling edge, optionally after a random gap, and
    // holds it until the block accepts it at a rising edge. The sender stays
    // idle in each cycle with the chance set for the phase.
    task automatic send_beat(input logic [2:0] m, input logic [9:0] a,
                             input logic signed [31:0] v,
                             input logic [9:0] i0, input logic [9:0] i1,
                             input logic [9:0] i2,
                             input logic signed [31:0] w0, input logic signed [31:0] w1,
                             input logic signed [31:0] w2, input logic rl);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        addr     <= a;
        value    <= v;
        idx0     <= i0;
        idx1     <= i1;
        idx2     <= i2;
        weight0  <= w0;
        weight1  <= w1;
        weight2  <= w2;
        row_last <= rl;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_layer_beat();
    endtask

    task automatic check_field(input string name, input logic signed [31:0] expv,
                               input logic signed [31:0] got);
        if (expv !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, expv, got);
        end
    endtask

    // Result checker: every accepted result beat is matched with the oldest
    // pending prediction.
    always @(posedge clk)
    begin
        mix_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, got %h %h %h %b",
                         $time, out0, out1, out2, last);
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("out0", e.out0, out0);
                check_field("out1", e.out1, out1);
                check_field("out2", e.out2, out2);
                check_field("last", {31'b0, e.last}, {31'b0, last});
            end
        end
    end

    // Random Q16.16 value: extremes, small fixed-point numbers, or full range.
    function automatic logic signed [31:0] pick_q();
        case ($urandom_range(9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3, 4, 5: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [9:0] pick_loaded();
        return 10'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
    endfunction

    // Backward and read beats mostly share a small hot region so that reads
    // see accumulated gradients.
    function automatic logic [9:0] pick_grad_idx();
        if ($urandom_range(99) < 60)
        begin
            return 10'($urandom_range(15));
        end
        return 10'($urandom_range(DEPTH - 1));
    endfunction

    task automatic test_load_extremes();
        send_beat(MODE_LOAD, 10'd0, 32'sh7FFFFFFF, 0, 0, 0, 0, 0, 0, 1'b0);
        send_beat(MODE_LOAD, 10'd1023, 32'sh80000000, 0, 0, 0, 0, 0, 0, 1'b1);
        send_beat(MODE_LOAD, 10'd1, 32'sh0001_0000, 0, 0, 0, 0, 0, 0, 1'b0);
        send_beat(MODE_LOAD, 10'd2, -32'sd1, 0, 0, 0, 0, 0, 0, 1'b0);
        send_beat(MODE_LOAD, 10'd3, 32'sd0, 0, 0, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_forward();
        // Positive and negative saturation of the sum, ordinary values, then positive saturation again.
        send_beat(MODE_FWD, 0, 0, 10'd0, 10'd0, 10'd0,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
        send_beat(MODE_FWD, 0, 0, 10'd0, 10'd1023, 10'd0,
                  32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
        send_beat(MODE_FWD, 0, 0, 10'd1, 10'd2, 10'd3,
                  32'sh0002_8000, 32'sh0000_0001, -32'sd3, 1'b0);
        send_beat(MODE_FWD, 0, 0, 10'd1023, 10'd1023, 10'd1023,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
    endtask

    task automatic test_pgrad();
        send_beat(MODE_PGRAD, 0, 32'sh7FFFFFFF, 10'd0, 10'd1023, 10'd2, 0, 0, 0, 1'b1);
        send_beat(MODE_PGRAD, 0, 32'sh80000000, 10'd1023, 10'd0, 10'd1, 0, 0, 0, 1'b0);
        send_beat(MODE_PGRAD, 0, -32'sd1, 10'd2, 10'd1, 10'd3, 0, 0, 0, 1'b0);
    endtask

    task automatic test_backward();
        // Repeated indices across the taps, driven to both saturation limits.
        send_beat(MODE_BWD, 0, 32'sh7FFFFFFF, 10'd5, 10'd5, 10'd5,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
        send_beat(MODE_BWD, 0, -32'sd1, 10'd6, 10'd1023, 10'd6,
                  32'sh0001_0000, 32'sh80000000, -32'sd1, 1'b1);
        send_beat(MODE_BWD, 0, 32'sh80000000, 10'd7, 10'd7, 10'd8,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh0000_8000, 1'b0);
    endtask

    task automatic test_read_clear();
        send_beat(MODE_READ, 10'd5, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_beat(MODE_READ, 10'd5, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_beat(MODE_READ, 10'd6, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_beat(MODE_READ, 10'd1023, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_beat(MODE_READ, 10'd7, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_beat(MODE_READ, 10'd8, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_unused_modes();
        send_beat(MODE_SPARE5, 10'd0, 32'sh7FFFFFFF, 10'd0, 10'd0, 10'd0,
                  32'sh7FFFFFFF, 0, 0, 1'b1);
        send_beat(MODE_SPARE6, 10'd5, -32'sd1, 10'd5, 10'd5, 10'd5, -32'sd1, -32'sd1,
                  -32'sd1, 1'b0);
        send_beat(MODE_SPARE7, 10'd1023, 32'sh80000000, 10'd1023, 10'd1023, 10'd1023,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
        // A read right after shows that the unused beats left the gradient alone.
        send_beat(MODE_READ, 10'd5, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        logic [2:0]         m;
        logic [9:0]         a;
        logic [9:0]         i0;
        logic [9:0]         i1;
        logic [9:0]         i2;
        logic signed [31:0] v;
        int                 pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            // Unused fields still carry random bits.
            a  = 10'($urandom_range(DEPTH - 1));
            i0 = 10'($urandom_range(DEPTH - 1));
            i1 = 10'($urandom_range(DEPTH - 1));
            i2 = 10'($urandom_range(DEPTH - 1));
            v  = pick_q();
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                m = MODE_LOAD;
            end
            else if (pick < 45)
            begin
                m = MODE_FWD;
            end
            else if (pick < 65)
            begin
                m = MODE_BWD;
            end
            else if (pick < 80)
            begin
                m = MODE_PGRAD;
            end
            else if (pick < 96)
            begin
                m = MODE_READ;
            end
            else
            begin
                m = 3'($urandom_range(MODE_SPARE5, MODE_SPARE7));
            end
            if (m == MODE_FWD || m == MODE_PGRAD)
            begin
                i0 = pick_loaded();
                i1 = pick_loaded();
                i2 = pick_loaded();
            end
            else if (m == MODE_BWD)
            begin
                i0 = pick_grad_idx();
                i1 = pick_grad_idx();
                i2 = pick_grad_idx();
            end
            else if (m == MODE_READ)
            begin
                a = pick_grad_idx();
            end
            send_beat(m, a, v, i0, i1, i2, pick_q(), pick_q(), pick_q(), 1'($urandom));
        end
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            grad_mirror[i] = '0;
            act_mirror[i]  = '0;
            act_loaded[i]  = 1'b0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part runs with both sides always ready to move.
        test_load_extremes();
        test_forward();
        test_pgrad();
        test_backward();
        test_read_clear();
        test_unused_modes();

        test_random(280, 0, 0);
        test_random(280, 56, 0);
        test_random(280, 0, 56);
        test_random(290, 7, 7);

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
